[rtl/assert_macros.svh]
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, muted during reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/wsls_pkg.sv]
package wsls_pkg;
  localparam int MaxWordsDef   = 128;
  localparam int WordBytesDef  = 128;
  localparam int TotalBytesDef = 1024;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_END  = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROP    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [7:0] SPACE_BYTE = 8'd32;
  localparam logic [7:0] NUL_BYTE   = 8'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_in;
  } wsls_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_char;
    logic       char_valid;
    logic       word_end;
    logic       list_end;
    logic [7:0] word_count;
  } wsls_out_t;

  typedef enum logic [3:0] {
    S_IDLE,    // wait for command
    S_EXEC,    // decode and act on latched item
    S_INIT,    // fill order table with identity
    S_RDI,     // read order[i]
    S_RDJ,     // read order[j]
    S_LENI,    // length of order[i]
    S_LENJ,    // length of order[j]
    S_CMP,     // compare, maybe swap
    S_POPA,    // read order[read_word]
    S_POPB,    // read length/start of word
    S_POPC,    // read byte
    S_POPD     // emit pop result
  } wsls_state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic init_step;
    logic rd_i;
    logic rd_j;
    logic len_i;
    logic len_j;
    logic cmp;
    logic pop_a;
    logic pop_b;
    logic pop_c;
    logic pop_d;
  } wsls_cmd_t;

  typedef struct packed {
    logic is_pop;      // pop in reading phase with words left
    logic sort_go;     // exec started a sort
    logic init_done;
    logic inner_done;  // j reached end after compare
    logic outer_done;  // no more i
    logic pop_byte;    // pop needs a byte read
  } wsls_stat_t;
endpackage

[rtl/word_split_length_sort.sv]
// word_split_length_sort
// Command channel: item (cmd, char_in) taken when start is high and busy low.
// Result channel: one result per item, shown for one cycle with done high;
// the receiver cannot stall, so results are never held.
// Push of a non-zero byte, illegal items, pops with no word left: result set in exec.
// Other pops: result follows the order, word record and byte reads
// through the registered RAM ports.
// A new item can be taken in the cycle its predecessor's result is shown.
// A legal end (or a pushed zero byte) runs the exchange sort before its
// result: a fill pass writes the identity order, then each (i, j) pair
// reads order[i], order[j], both lengths and compares; busy stays high.
// Reset empties the sentence and returns to loading; the stores need no
// clearing pass since no entry is read before it is written.
module word_split_length_sort import wsls_pkg::*; #(
  parameter int MaxWords   = MaxWordsDef,
  parameter int WordBytes  = WordBytesDef,
  parameter int TotalBytes = TotalBytesDef
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  wsls_in_t  item_in,
  output logic      busy,
  output logic      done,
  output wsls_out_t result
);
  wsls_cmd_t  cmd;
  wsls_stat_t stat;

  wsls_ctrl u_ctrl (.clk, .rst, .start, .stat, .cmd, .busy);
  wsls_dp #(.MaxWords(MaxWords), .WordBytes(WordBytes), .TotalBytes(TotalBytes)) u_dp (
    .clk, .rst, .item_in, .cmd, .stat, .done, .result);
endmodule

[rtl/wsls_ram.sv]
module wsls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/wsls_ctrl.sv]
module wsls_ctrl import wsls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  wsls_stat_t stat,
  output wsls_cmd_t  cmd,
  output logic       busy
);
  wsls_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EXEC;
      S_EXEC: begin
        if (stat.sort_go) state_next = S_INIT;
        else if (stat.is_pop) state_next = S_POPA;
        else state_next = S_IDLE;
      end
      S_INIT: if (stat.init_done) state_next = stat.outer_done ? S_IDLE : S_RDI;
      S_RDI:  state_next = S_RDJ;
      S_RDJ:  state_next = S_LENI;
      S_LENI: state_next = S_LENJ;
      S_LENJ: state_next = S_CMP;
      S_CMP: begin
        if (stat.inner_done && stat.outer_done) state_next = S_IDLE;
        else state_next = S_RDI;
      end
      S_POPA: state_next = S_POPB;
      S_POPB: state_next = S_POPC;
      S_POPC: state_next = S_POPD;
      S_POPD: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: cmd.latch = start;
      S_EXEC: cmd.exec = 1'b1;
      S_INIT: cmd.init_step = 1'b1;
      S_RDI:  cmd.rd_i = 1'b1;
      S_RDJ:  cmd.rd_j = 1'b1;
      S_LENI: cmd.len_i = 1'b1;
      S_LENJ: cmd.len_j = 1'b1;
      S_CMP:  cmd.cmp = 1'b1;
      S_POPA: cmd.pop_a = 1'b1;
      S_POPB: cmd.pop_b = 1'b1;
      S_POPC: cmd.pop_c = 1'b1;
      S_POPD: cmd.pop_d = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

[rtl/wsls_dp.sv]
module wsls_dp import wsls_pkg::*; #(
  parameter int MaxWords   = MaxWordsDef,
  parameter int WordBytes  = WordBytesDef,
  parameter int TotalBytes = TotalBytesDef
) (
  input  logic       clk,
  input  logic       rst,
  input  wsls_in_t   item_in,
  input  wsls_cmd_t  cmd,
  output wsls_stat_t stat,
  output logic       done,
  output wsls_out_t  result
);
  localparam int AW = $clog2(MaxWords);
  localparam int WCW = $clog2(MaxWords + 1);
  localparam int LW = $clog2(WordBytes);
  localparam int BW = $clog2(TotalBytes);
  localparam int PW = $clog2(TotalBytes + 1);

  wsls_in_t item;
  logic [WCW-1:0] words_found;
  logic [PW-1:0]  write_pointer;
  logic [LW-1:0]  current_length;
  logic           reading;
  logic [WCW-1:0] read_word;
  logic [LW-1:0]  read_offset;
  logic [WCW-1:0] si, sj;
  logic [AW-1:0]  oi, oj;
  logic [LW-1:0]  li;
  logic [LW-1:0]  cur_len;
  logic [BW-1:0]  cur_start;

  // memories
  logic          b_we;  logic [BW-1:0] b_wa, b_ra; logic [7:0] b_rd;
  logic          s_we;  logic [AW-1:0] s_wa, s_ra; logic [BW-1:0] s_rd;
  logic          l_we;  logic [AW-1:0] l_wa, l_ra; logic [LW-1:0] l_rd, l_wd;
  logic          o_we;  logic [AW-1:0] o_wa, o_ra, o_rd, o_wd;
  logic [BW-1:0] s_wd;

  wsls_ram #(.Width(8), .Depth(TotalBytes)) u_bytes (
    .clk, .we(b_we), .waddr(b_wa), .wdata(item.char_in), .raddr(b_ra), .rdata(b_rd));
  wsls_ram #(.Width(BW), .Depth(MaxWords)) u_start (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  wsls_ram #(.Width(LW), .Depth(MaxWords)) u_len (
    .clk, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  wsls_ram #(.Width(AW), .Depth(MaxWords)) u_order (
    .clk, .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  // exec decode
  logic clr, is_push, is_end, is_pop, closing, finishing, full_words, store_ok;
  logic [1:0] ex_status;
  logic [WCW-1:0] wf_eff;
  logic [PW-1:0]  wp_eff;
  logic [LW-1:0]  cl_eff;
  always_comb begin
    is_push = item.cmd == CMD_PUSH;
    is_end  = item.cmd == CMD_END;
    is_pop  = item.cmd == CMD_POP;
    clr = (is_push || is_end) && reading && (read_word >= words_found);
    wf_eff = clr ? '0 : words_found;
    wp_eff = clr ? '0 : write_pointer;
    cl_eff = clr ? '0 : current_length;
    full_words = wf_eff >= WCW'(MaxWords);
    closing = 1'b0; finishing = 1'b0; store_ok = 1'b0;
    ex_status = ST_OK;
    if ((is_push || is_end) && reading && !clr) begin
      ex_status = ST_ILLEGAL;
    end else if (is_push) begin
      if (item.char_in == SPACE_BYTE) closing = 1'b1;
      else if (item.char_in == NUL_BYTE) begin closing = 1'b1; finishing = 1'b1; end
      else if (full_words || cl_eff >= LW'(WordBytes - 1) || wp_eff >= PW'(TotalBytes))
        ex_status = ST_DROP;
      else store_ok = 1'b1;
    end else if (is_end) begin
      closing = 1'b1; finishing = 1'b1;
    end else if (is_pop) begin
      if (!reading) ex_status = ST_ILLEGAL;
    end else begin
      ex_status = ST_ILLEGAL;
    end
    if (closing && full_words) ex_status = ST_DROP;
  end

  logic pop_live;
  assign pop_live = is_pop && reading && (read_word < words_found);
  logic [WCW-1:0] wf_new;
  assign wf_new = (closing && !full_words) ? wf_eff + 1'b1 : wf_eff;

  always_comb begin
    stat.is_pop     = pop_live;
    stat.sort_go    = finishing && ex_status != ST_ILLEGAL;
    stat.init_done  = (si + 1'b1) >= words_found;
    stat.inner_done = (sj + 1'b1) >= words_found;
    stat.outer_done = cmd.init_step ? (words_found < WCW'(2))
                                    : ((si + 2'd2) >= {1'b0, words_found});
    stat.pop_byte   = read_offset < cur_len;
  end

  // second swap write (order[j] <= oi), in the cycle after cmp, while the
  // controller sits in RDI or IDLE
  logic swap2;
  logic [AW-1:0] swap_a, swap_d;

  // memory control
  always_comb begin
    b_we = cmd.exec && store_ok;
    b_wa = wp_eff[BW-1:0];
    s_we = cmd.exec && closing && !full_words;
    s_wa = wf_eff[AW-1:0];
    s_wd = BW'(wp_eff - PW'(cl_eff));
    l_we = 1'b0; l_wa = wf_eff[AW-1:0]; l_wd = cl_eff;
    if (cmd.exec && closing && !full_words) l_we = 1'b1;
    o_we = 1'b0; o_wa = si[AW-1:0]; o_wd = si[AW-1:0];
    if (cmd.init_step) o_we = 1'b1;
    else if (cmd.cmp && (li > l_rd)) o_we = 1'b1;
    if (cmd.cmp) begin o_wa = si[AW-1:0]; o_wd = oj; end
    if (swap2) begin o_we = 1'b1; o_wa = swap_a; o_wd = swap_d; end
    o_ra = cmd.rd_i ? si[AW-1:0] : cmd.rd_j ? sj[AW-1:0] : read_word[AW-1:0];
    // length lookup follows the order entry just read; holds oj otherwise
    l_ra = (cmd.rd_j || cmd.len_i || cmd.pop_a || cmd.pop_b) ? o_rd : oj;
    s_ra = o_rd;
    b_ra = BW'(cur_start + BW'(read_offset));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_found <= '0; write_pointer <= '0; current_length <= '0;
      reading <= 1'b0; read_word <= '0; read_offset <= '0;
      done <= 1'b0; swap2 <= 1'b0;
    end else begin
      done <= 1'b0; swap2 <= 1'b0;
      if (cmd.latch) item <= item_in;
      if (cmd.exec) begin
        result <= '0;
        result.status <= ex_status;
        if (is_pop && reading && !pop_live) result.list_end <= 1'b1;
        if (clr) begin reading <= 1'b0; read_word <= '0; read_offset <= '0; end
        words_found <= wf_new;
        write_pointer <= store_ok ? wp_eff + 1'b1 : wp_eff;
        current_length <= closing ? '0 : (store_ok ? cl_eff + 1'b1 : cl_eff);
        result.word_count <= 8'(wf_new);
        if (stat.sort_go) begin
          reading <= 1'b1; read_word <= '0; read_offset <= '0; si <= '0;
        end else if (!pop_live) done <= 1'b1;
      end
      if (cmd.init_step) begin
        if (stat.init_done) begin
          si <= '0; sj <= WCW'(1);
          if (stat.outer_done) done <= 1'b1;
        end else si <= si + 1'b1;
      end
      if (cmd.rd_j) oi <= o_rd;
      if (cmd.len_i) begin oj <= o_rd; li <= l_rd; end
      if (cmd.cmp) begin
        if (li > l_rd) begin swap2 <= 1'b1; swap_a <= sj[AW-1:0]; swap_d <= oi; end
        if (stat.inner_done) begin
          if (stat.outer_done) done <= 1'b1;
          si <= si + 1'b1; sj <= si + 2'd2;
        end else sj <= sj + 1'b1;
      end
      if (cmd.pop_b) begin cur_len <= l_rd; cur_start <= s_rd; end
      if (cmd.pop_d) begin
        done <= 1'b1;
        if (stat.pop_byte) begin
          result.out_char <= b_rd; result.char_valid <= 1'b1;
        end
        if (read_offset + LW'(stat.pop_byte) >= cur_len) begin
          result.word_end <= 1'b1;
          read_word <= read_word + 1'b1; read_offset <= '0;
          if (read_word + 1'b1 >= words_found) result.list_end <= 1'b1;
        end else read_offset <= read_offset + 1'b1;
      end
    end
  end
endmodule

[rtl/wsls_checker.sv]
`include "assert_macros.svh"
module wsls_checker import wsls_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input wsls_out_t result
);
  `CHK_NEXT(a_busy_after_start, clk, rst, start && !busy, busy, "no busy after accept")
  `CHK_IMPL(a_done_pulse, clk, rst, done, $past(busy), "result without item")
  `CHK_IMPL(a_char_ok, clk, rst, done && result.char_valid, result.status == ST_OK, "bad byte")
endmodule
bind word_split_length_sort wsls_checker u_chk (.clk, .rst, .start, .busy, .done, .result);
